[hw/rtl/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg: shared constants and helpers for the Playfair digraph cipher
// Letter codes, command codes, square geometry and cell arithmetic.
// ----------------------------------------------------------------------------
package pfc_pkg;

	localparam int LETTER_W = 5;
	localparam int CELL_W   = 5;
	localparam int GRID     = 5;
	localparam int CELLS    = GRID * GRID;
	localparam int ALPHA    = 26;

	localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
	localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
	localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

	localparam logic [CELL_W-1:0] CELLS_C = 5'd25;

	typedef enum logic [1:0] {
		CMD_KEY    = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_ENC    = 2'd2,
		CMD_DEC    = 2'd3
	} cmd_t;

	typedef logic [2:0] coord_t;

	// Row of a cell index below 25.
	function automatic coord_t cell_row(input logic [CELL_W-1:0] c);
		coord_t r;
		if (c >= 5'd20) r = 3'd4;
		else if (c >= 5'd15) r = 3'd3;
		else if (c >= 5'd10) r = 3'd2;
		else if (c >= 5'd5) r = 3'd1;
		else r = 3'd0;
		return r;
	endfunction

	// Column of a cell index below 25.
	function automatic coord_t cell_col(input logic [CELL_W-1:0] c);
		coord_t r;
		logic [CELL_W-1:0] base;
		r = cell_row(c);
		base = {r[2:0], 2'b00} + {2'b00, r};
		return coord_t'(c - base);
	endfunction

	// One step around the square, forward or backward, modulo five.
	function automatic coord_t coord_step(input coord_t v, input logic back);
		coord_t n;
		if (back) n = (v == 3'd0) ? 3'd4 : v - 3'd1;
		else n = (v == 3'd4) ? 3'd0 : v + 3'd1;
		return n;
	endfunction

	function automatic logic [CELL_W-1:0] cell_addr(input coord_t r, input coord_t c);
		return {r[2:0], 2'b00} + {2'b00, r} + {2'b00, c};
	endfunction

endpackage

[hw/rtl/pfc_ram.sv]
// ----------------------------------------------------------------------------
// pfc_ram: generic synchronous RAM
// One write port and two read ports, each read registered with its own enable.
// ----------------------------------------------------------------------------
module pfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en_a,
	input  logic [AW-1:0]    rd_addr_a,
	output logic [WIDTH-1:0] rd_data_a,
	input  logic             rd_en_b,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en_a) begin
			rd_data_a <= mem_q[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

[hw/rtl/playfair_digraph_cipher.sv]
// ----------------------------------------------------------------------------
// playfair_digraph_cipher: Playfair cipher on a 5x5 square without J
// Builds the key square from key words, then enciphers or deciphers letter
// pairs by the row, column and rectangle rules.
// ----------------------------------------------------------------------------
//  channel   direction  tdata[7:0]              tuser          tlast
//  s_axis    in         letter in [4:0]         cmd [1:0]      last
//  m_axis    out        out_letter in [4:0]     lower          out_last
//
//  A key word is placed as it is accepted. A finish word walks all 26
//  letters, one per cycle, while the input stalls. Each cipher pair passes
//  four steps: accept, letter-to-cell RAM read, square RAM read, output load;
//  a doubled plaintext letter with last produces a second pair.
//  A pair waits in the output load step until both previous result words
//  have left the two-entry output buffer. Reset clears all control state;
//  the two RAMs are written during key building and need no clearing.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [4:0] letter, [7:5] zero
	input  logic [1:0] s_axis_tuser,   // [1:0] cmd
	input  logic       s_axis_tlast,   // last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [4:0] out_letter, [7:5] zero
	output logic       m_axis_tuser,   // [0] lower
	output logic       m_axis_tlast    // out_last
);

	localparam int LW = pfc_pkg::LETTER_W;
	localparam int CW = pfc_pkg::CELL_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_FILL = 5'b00010,
		ST_CELL = 5'b00100,
		ST_SQ   = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [pfc_pkg::ALPHA-1:0] used_q;
	logic [CW-1:0]             fill_q;
	logic                      key_ready_q;
	logic                      held_v_q;
	logic [LW-1:0]             held_q;
	logic [LW-1:0]             fa_q;

	// Pair job.
	logic [LW-1:0] pa_q, pb_q, sec_q;
	logic          dec_q, fin_q, second_q;

	// Output buffer, slot 0 is at the port.
	logic [1:0]    ob_v_q;
	logic [LW-1:0] ob_letter_q [2];
	logic [1:0]    ob_last_q;
	logic          ob_lower_q;

	logic          acc;
	pfc_pkg::cmd_t cmd;
	logic [LW-1:0] lsat, lci;
	logic          is_dec;

	logic          place_en;
	logic [LW-1:0] place_letter;

	logic [CW-1:0] cell_a, cell_b;
	logic [CW-1:0] sq_x, sq_y;
	logic [CW-1:0] sq_addr_x, sq_addr_y;
	pfc_pkg::coord_t r1, c1, r2, c2;

	logic pop;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc    = s_axis_tvalid && s_axis_tready;
	assign cmd    = pfc_pkg::cmd_t'(s_axis_tuser);
	assign lsat   = (s_axis_tdata[4:0] > pfc_pkg::LETTER_Z) ? pfc_pkg::LETTER_Z
	                                                        : s_axis_tdata[4:0];
	assign lci    = (lsat == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : lsat;
	assign is_dec = (cmd == pfc_pkg::CMD_DEC);

	// A letter takes the next free cell unless it is J, already placed, or the
	// square is full.
	always_comb begin
		place_letter = (state_q == ST_FILL) ? fa_q : lsat;
		place_en = 1'b0;
		if ((place_letter != pfc_pkg::LETTER_J) && !used_q[place_letter] &&
		    (fill_q < pfc_pkg::CELLS_C)) begin
			if (state_q == ST_FILL) begin
				place_en = 1'b1;
			end else if (acc && (cmd == pfc_pkg::CMD_KEY) && !key_ready_q) begin
				place_en = 1'b1;
			end
		end
	end

	pfc_ram #(
		.WIDTH(CW),
		.DEPTH(pfc_pkg::ALPHA)
	) u_cell_ram (
		.clk      (clk),
		.wr_en    (place_en),
		.wr_addr  (place_letter),
		.wr_data  (fill_q),
		.rd_en_a  (state_q == ST_CELL),
		.rd_addr_a(pa_q),
		.rd_data_a(cell_a),
		.rd_en_b  (state_q == ST_CELL),
		.rd_addr_b(pb_q),
		.rd_data_b(cell_b)
	);

	// Square addresses of the two result letters.
	always_comb begin
		r1 = pfc_pkg::cell_row(cell_a);
		c1 = pfc_pkg::cell_col(cell_a);
		r2 = pfc_pkg::cell_row(cell_b);
		c2 = pfc_pkg::cell_col(cell_b);
		if (r1 == r2) begin
			sq_addr_x = pfc_pkg::cell_addr(r1, pfc_pkg::coord_step(c1, dec_q));
			sq_addr_y = pfc_pkg::cell_addr(r2, pfc_pkg::coord_step(c2, dec_q));
		end else if (c1 == c2) begin
			sq_addr_x = pfc_pkg::cell_addr(pfc_pkg::coord_step(r1, dec_q), c1);
			sq_addr_y = pfc_pkg::cell_addr(pfc_pkg::coord_step(r2, dec_q), c2);
		end else begin
			sq_addr_x = pfc_pkg::cell_addr(r1, c2);
			sq_addr_y = pfc_pkg::cell_addr(r2, c1);
		end
	end

	pfc_ram #(
		.WIDTH(LW),
		.DEPTH(pfc_pkg::CELLS)
	) u_square_ram (
		.clk      (clk),
		.wr_en    (place_en),
		.wr_addr  (fill_q),
		.wr_data  (place_letter),
		.rd_en_a  (state_q == ST_SQ),
		.rd_addr_a(sq_addr_x),
		.rd_data_a(sq_x),
		.rd_en_b  (state_q == ST_SQ),
		.rd_addr_b(sq_addr_y),
		.rd_data_b(sq_y)
	);

	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			fill_q      <= '0;
			key_ready_q <= 1'b0;
			held_v_q    <= 1'b0;
			held_q      <= '0;
			fa_q        <= '0;
			second_q    <= 1'b0;
			ob_v_q      <= '0;
		end else begin
			if (place_en) begin
				used_q[place_letter] <= 1'b1;
				fill_q <= fill_q + 5'd1;
			end
			if (pop) begin
				ob_v_q <= {1'b0, ob_v_q[1]};
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && !key_ready_q && (cmd == pfc_pkg::CMD_FINISH)) begin
						fa_q    <= '0;
						state_q <= ST_FILL;
					end else if (acc && key_ready_q &&
					             ((cmd == pfc_pkg::CMD_ENC) || (cmd == pfc_pkg::CMD_DEC))) begin
						if (held_v_q) begin
							if (!is_dec && (held_q == lci)) begin
								// Doubled plaintext: pad the held letter with X.
								second_q <= s_axis_tlast;
								held_v_q <= !s_axis_tlast;
								held_q   <= lci;
								state_q  <= ST_CELL;
							end else begin
								second_q <= 1'b0;
								held_v_q <= 1'b0;
								state_q  <= ST_CELL;
							end
						end else if (s_axis_tlast) begin
							second_q <= 1'b0;
							held_v_q <= 1'b0;
							state_q  <= ST_CELL;
						end else begin
							held_v_q <= 1'b1;
							held_q   <= lci;
						end
					end
				end
				ST_FILL: begin
					fa_q <= fa_q + 5'd1;
					if (fa_q == pfc_pkg::LETTER_Z) begin
						key_ready_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_CELL: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!ob_v_q[0]) begin
						ob_v_q <= 2'b11;
						if (second_q) begin
							second_q <= 1'b0;
							state_q  <= ST_CELL;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pair job and output payload.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && acc) begin
			dec_q <= is_dec;
			sec_q <= lci;
			if (held_v_q) begin
				pa_q <= held_q;
				if (!is_dec && (held_q == lci)) begin
					pb_q  <= pfc_pkg::LETTER_X;
					fin_q <= 1'b0;
				end else begin
					pb_q  <= lci;
					fin_q <= s_axis_tlast;
				end
			end else begin
				pa_q  <= lci;
				pb_q  <= pfc_pkg::LETTER_X;
				fin_q <= 1'b1;
			end
		end
		if ((state_q == ST_OUT) && !ob_v_q[0]) begin
			ob_letter_q[0] <= sq_x;
			ob_letter_q[1] <= sq_y;
			ob_last_q      <= {fin_q, 1'b0};
			ob_lower_q     <= dec_q;
			if (second_q) begin
				pa_q  <= sec_q;
				pb_q  <= pfc_pkg::LETTER_X;
				fin_q <= 1'b1;
			end
		end else if (pop) begin
			ob_letter_q[0] <= ob_letter_q[1];
			ob_last_q      <= {1'b0, ob_last_q[1]};
		end
	end

	assign m_axis_tvalid = ob_v_q[0];
	assign m_axis_tdata  = {3'b000, ob_letter_q[0]};
	assign m_axis_tuser  = ob_lower_q;
	assign m_axis_tlast  = ob_last_q[0];

endmodule

[hw/rtl/pfc_checker.sv]
// ----------------------------------------------------------------------------
// pfc_checker: port-level checks for the Playfair digraph cipher
// Watches the streams for result letter range, no J in results, and stall behavior.
// ----------------------------------------------------------------------------
module pfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic [1:0] s_axis_tuser,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser,
	input logic       m_axis_tlast
);

	// Every result word names a letter code no higher than Z.
	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[4:0] <= pfc_pkg::LETTER_Z))
		else $error("result letter out of range");

	// A result is never J, since the square holds no J.
	a_no_j: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[4:0] != pfc_pkg::LETTER_J))
		else $error("result letter is J");

	// A stalled result word holds its letter, flag and last marker.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		 $stable(m_axis_tlast)))
		else $error("stalled result word changed");

	// An offered input word stays on the bus until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && !s_axis_tready) |=>
		(s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser) &&
		 $stable(s_axis_tlast)))
		else $error("stalled input word changed");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
